// ===== src/nrcw_pkg.sv =====
package nrcw_pkg;

    // event codes on s_req_type
    localparam logic [2:0] REQ_SENT      = 3'd0;
    localparam logic [2:0] REQ_ACKED     = 3'd1;
    localparam logic [2:0] REQ_LOST      = 3'd2;
    localparam logic [2:0] REQ_LOSS_DONE = 3'd3;
    localparam logic [2:0] REQ_INVAL     = 3'd4;
    localparam logic [2:0] REQ_ECN       = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_DGRAM = 2'd0;
    localparam logic [1:0] CFG_LOSS_NUM  = 2'd1;
    localparam logic [1:0] CFG_LOSS_DEN  = 2'd2;

    // result codes
    localparam logic       STATUS_OK     = 1'b0;
    localparam logic       STATUS_REJECT = 1'b1;
    localparam logic [1:0] PHASE_SLOW_START = 2'd0;
    localparam logic [1:0] PHASE_AVOIDANCE  = 2'd1;
    localparam logic [1:0] PHASE_RECOVERY   = 2'd2;

    // datagram size limits and initial window floor
    localparam logic [15:0] DGRAM_MIN      = 16'd1200;
    localparam logic [16:0] INIT_WND_FLOOR = 17'd14720;

    // main sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACK_FLAGS,
        ST_ACK_TEST,
        ST_ACK_CREDIT,
        ST_ACK_GROW,
        ST_CONG_CHECK,
        ST_CONG_WAIT,
        ST_CONG_WIN,
        ST_FLUSH_END,
        ST_RESP
    } nrcw_state_t;

    // multiply-divide unit states
    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL_LO,
        MD_MUL_HI,
        MD_CHECK,
        MD_DIV,
        MD_DONE
    } md_state_t;

    // request to the multiply-divide unit
    typedef struct packed {
        logic        start;
        logic [63:0] mult;
        logic [15:0] num;
        logic [15:0] den;
    } md_cmd_t;

    // answer from the multiply-divide unit
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } md_rsp_t;

endpackage

// ===== src/nrcw_muldiv.sv =====
module nrcw_muldiv
    import nrcw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  md_cmd_t md_cmd,
    output md_rsp_t md_rsp
);

    md_state_t   state_reg, state_next;
    logic [63:0] a_reg;
    logic [15:0] num_reg;
    logic [15:0] den_reg;
    logic [47:0] plo_reg;
    logic [47:0] phi_reg;
    logic [15:0] rem_reg;
    logic [63:0] w_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] mul_a;
    logic [47:0] mul_out;
    logic [79:0] prod;
    logic        overflow;
    logic [16:0] shifted;
    logic [16:0] diff;
    logic        fits;

    // single 32x16 multiplier shared by both halves of the operand
    assign mul_a   = (state_reg == MD_MUL_LO) ? a_reg[31:0] : a_reg[63:32];
    assign mul_out = 48'(mul_a) * 48'(num_reg);

    // full product and quotient overflow test
    assign prod     = {phi_reg, 32'd0} + {32'd0, plo_reg};
    assign overflow = (den_reg == 16'd0) || (prod[79:64] >= den_reg);

    // one restoring division step
    assign shifted = {rem_reg, w_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE:   if (md_cmd.start) state_next = MD_MUL_LO;
            MD_MUL_LO: state_next = MD_MUL_HI;
            MD_MUL_HI: state_next = MD_CHECK;
            MD_CHECK:  state_next = overflow ? MD_DONE : MD_DIV;
            MD_DIV:    if (cnt_reg == '1) state_next = MD_DONE;
            MD_DONE:   state_next = MD_IDLE;
            default:   state_next = MD_IDLE;
        endcase
    end

    // operand capture, partial products and quotient shift register
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            MD_IDLE: begin
                if (md_cmd.start) begin
                    a_reg   <= md_cmd.mult;
                    num_reg <= md_cmd.num;
                    den_reg <= md_cmd.den;
                end
            end
            MD_MUL_LO: plo_reg <= mul_out;
            MD_MUL_HI: phi_reg <= mul_out;
            MD_CHECK: begin
                cnt_reg <= '0;
                rem_reg <= prod[79:64];
                w_reg   <= overflow ? '1 : prod[63:0];
            end
            MD_DIV: begin
                cnt_reg <= cnt_reg + 6'd1;
                rem_reg <= fits ? diff[15:0] : shifted[15:0];
                w_reg   <= {w_reg[62:0], fits};
            end
            default: begin
            end
        endcase
    end

    assign md_rsp.done = (state_reg == MD_DONE);
    assign md_rsp.quot = w_reg;

endmodule

// ===== src/newreno_congestion_window_unit.sv =====
// NewReno congestion window controller. Each input transfer carries one event
// (sent, acked, lost, loss batch finished, invalidated, ECN) and yields exactly
// one result transfer with the status, transmit allowance, window, threshold,
// bytes in flight and phase after the event. The block takes one event at a
// time and s_ready is low while an event is worked on. Sent, invalidated,
// lost and unknown events go straight to the result; acked events pass the
// flag and test steps and, if needed, the credit and growth steps; a loss
// flush or ECN may start a congestion episode, which waits for the
// multiply-divide unit that forms window*num/den with one 32x16 multiplier
// used for the low and then the high operand half, and a restoring divider
// that produces one quotient bit per cycle, or all ones on overflow. A
// finished result waits in the output register until taken, and the next
// event is accepted meanwhile. Configuration writes take effect at once and
// are meant for idle periods only.
module newreno_congestion_window_unit
    import nrcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // event channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [63:0] s_byte_count,
    input  logic [63:0] s_send_time,
    input  logic [63:0] s_now_time,
    input  logic        s_persistent_flag,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [63:0] m_tx_allowance,
    output logic [63:0] m_window_out,
    output logic [63:0] m_threshold_out,
    output logic [63:0] m_inflight_out,
    output logic [1:0]  m_phase
);

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        return (b > a) ? 64'd0 : a - b;
    endfunction

    // min(10*m, max(2*m, floor))
    function automatic logic [63:0] init_wnd(input logic [15:0] m);
        logic [19:0] w10;
        logic [16:0] cap;
        w10 = {1'b0, m, 3'd0} + {3'd0, m, 1'b0};
        cap = ({m, 1'b0} < INIT_WND_FLOOR) ? INIT_WND_FLOOR : {m, 1'b0};
        return (w10 > {3'd0, cap}) ? {47'd0, cap} : {44'd0, w10};
    endfunction

    nrcw_state_t state_reg, state_next;

    // configuration
    logic [15:0] max_dgram_reg;
    logic [15:0] loss_num_reg;
    logic [15:0] loss_den_reg;

    // controller state
    logic [63:0] window_reg;
    logic [63:0] inflight_reg;
    logic [63:0] threshold_reg;
    logic [63:0] credit_reg;
    logic [63:0] rec_start_reg;
    logic [63:0] last_loss_reg;
    logic        loss_pending_reg;
    logic        in_recovery_reg;

    // captured event
    logic [2:0]  req_reg;
    logic [63:0] size_reg;
    logic [63:0] tx_time_reg;
    logic [63:0] now_reg;
    logic        persist_reg;
    logic        status_reg;

    // acked event scratch
    logic [63:0] rem_reg;
    logic        ge_reg;
    logic        lt_reg;
    logic        tok_reg;

    // result register
    logic        m_valid_reg;
    logic        m_status_reg;
    logic [63:0] m_allow_reg;
    logic [63:0] m_window_reg;
    logic [63:0] m_thresh_reg;
    logic [63:0] m_inflight_reg;
    logic [1:0]  m_phase_reg;

    logic [63:0] min_wnd;
    logic [63:0] three_dgram;
    logic        cong_limited;
    logic        cong_go;
    logic        resp_load;
    md_cmd_t     md_cmd;
    md_rsp_t     md_rsp;

    assign min_wnd     = {47'd0, max_dgram_reg, 1'b0};
    assign three_dgram = {46'd0, {1'b0, max_dgram_reg, 1'b0} + {2'd0, max_dgram_reg}};

    // sender is limited by the window
    assign cong_limited = ge_reg
                        || (lt_reg && (rem_reg <= {1'b0, window_reg[63:1]}))
                        || (rem_reg <= three_dgram);

    // congestion episode starts only for losses sent after the last recovery
    assign cong_go   = last_loss_reg > rec_start_reg;
    assign resp_load = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    assign md_cmd.start = (state_reg == ST_CONG_CHECK) && cong_go;
    assign md_cmd.mult  = window_reg;
    assign md_cmd.num   = loss_num_reg;
    assign md_cmd.den   = loss_den_reg;

    nrcw_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .md_cmd  (md_cmd),
        .md_rsp  (md_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                priority case (req_reg)
                    REQ_ACKED:     state_next = ST_ACK_FLAGS;
                    REQ_LOSS_DONE: state_next = loss_pending_reg ? ST_CONG_CHECK : ST_RESP;
                    REQ_ECN:       state_next = ST_CONG_CHECK;
                    default:       state_next = ST_RESP;
                endcase
            end
            ST_ACK_FLAGS: state_next = ST_ACK_TEST;
            ST_ACK_TEST: begin
                if (!cong_limited || !tok_reg || lt_reg) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_ACK_CREDIT;
                end
            end
            ST_ACK_CREDIT: begin
                state_next = (credit_reg >= window_reg) ? ST_ACK_GROW : ST_RESP;
            end
            ST_ACK_GROW:   state_next = ST_RESP;
            ST_CONG_CHECK: state_next = cong_go ? ST_CONG_WAIT : ST_FLUSH_END;
            ST_CONG_WAIT: begin
                if (md_rsp.done) state_next = ST_CONG_WIN;
            end
            ST_CONG_WIN:  state_next = ST_FLUSH_END;
            ST_FLUSH_END: state_next = ST_RESP;
            ST_RESP: begin
                if (resp_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dgram_reg    <= DGRAM_MIN;
            loss_num_reg     <= 16'd1;
            loss_den_reg     <= 16'd2;
            window_reg       <= init_wnd(DGRAM_MIN);
            inflight_reg     <= '0;
            threshold_reg    <= '1;
            credit_reg       <= '0;
            rec_start_reg    <= '0;
            last_loss_reg    <= '0;
            loss_pending_reg <= 1'b0;
            in_recovery_reg  <= 1'b0;
        end else begin
            // register writes; the user is to make them only while idle, unchecked here
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MAX_DGRAM: begin
                        if (cfg_wdata >= DGRAM_MIN) begin
                            max_dgram_reg <= cfg_wdata;
                            if (cfg_wdata < max_dgram_reg) window_reg <= init_wnd(cfg_wdata);
                        end
                    end
                    CFG_LOSS_NUM: loss_num_reg <= cfg_wdata;
                    CFG_LOSS_DEN: loss_den_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            unique case (state_reg)
                ST_EXEC: begin
                    priority case (req_reg)
                        REQ_SENT:  inflight_reg <= sat_add64(inflight_reg, size_reg);
                        REQ_INVAL: inflight_reg <= sat_sub64(inflight_reg, size_reg);
                        REQ_ACKED: inflight_reg <= sat_sub64(inflight_reg, size_reg);
                        REQ_LOST: begin
                            if (size_reg <= inflight_reg) begin
                                inflight_reg <= inflight_reg - size_reg;
                                if (tx_time_reg > last_loss_reg) begin
                                    last_loss_reg <= tx_time_reg;
                                    if (!loss_pending_reg) begin
                                        loss_pending_reg <= 1'b1;
                                        credit_reg       <= '0;
                                    end
                                end
                            end
                        end
                        REQ_ECN: begin
                            loss_pending_reg <= 1'b1;
                            credit_reg       <= '0;
                            last_loss_reg    <= tx_time_reg;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_ACK_TEST: begin
                    if (cong_limited && tok_reg) begin
                        if (lt_reg) begin
                            window_reg      <= sat_add64(window_reg, size_reg);
                            in_recovery_reg <= 1'b0;
                        end else begin
                            credit_reg <= sat_add64(credit_reg, size_reg);
                        end
                    end
                end
                ST_ACK_CREDIT: begin
                    if (credit_reg >= window_reg) begin
                        credit_reg <= credit_reg - window_reg;
                    end else begin
                        in_recovery_reg <= 1'b0;
                    end
                end
                ST_ACK_GROW: begin
                    window_reg      <= sat_add64(window_reg, {48'd0, max_dgram_reg});
                    in_recovery_reg <= 1'b0;
                end
                ST_CONG_WAIT: begin
                    if (md_rsp.done) begin
                        threshold_reg   <= md_rsp.quot;
                        in_recovery_reg <= 1'b1;
                        rec_start_reg   <= now_reg;
                    end
                end
                ST_CONG_WIN: begin
                    window_reg <= (threshold_reg < min_wnd) ? min_wnd : threshold_reg;
                end
                ST_FLUSH_END: begin
                    if ((req_reg == REQ_LOSS_DONE) && persist_reg) begin
                        window_reg    <= min_wnd;
                        rec_start_reg <= '0;
                    end
                    loss_pending_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // event capture, status and acked-event flags
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            req_reg     <= s_req_type;
            size_reg    <= s_byte_count;
            tx_time_reg <= s_send_time;
            now_reg     <= s_now_time;
            persist_reg <= s_persistent_flag;
        end
        if (state_reg == ST_EXEC) begin
            status_reg <= ((req_reg == REQ_LOST) && (size_reg > inflight_reg)) ?
                          STATUS_REJECT : STATUS_OK;
        end
        if (state_reg == ST_ACK_FLAGS) begin
            rem_reg <= window_reg - inflight_reg;
            ge_reg  <= inflight_reg >= window_reg;
            lt_reg  <= window_reg < threshold_reg;
            tok_reg <= tx_time_reg > rec_start_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (resp_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_load) begin
            m_status_reg   <= status_reg;
            m_allow_reg    <= (inflight_reg >= window_reg) ? 64'd0 : window_reg - inflight_reg;
            m_window_reg   <= window_reg;
            m_thresh_reg   <= threshold_reg;
            m_inflight_reg <= inflight_reg;
            if (in_recovery_reg) begin
                m_phase_reg <= PHASE_RECOVERY;
            end else if (window_reg < threshold_reg) begin
                m_phase_reg <= PHASE_SLOW_START;
            end else begin
                m_phase_reg <= PHASE_AVOIDANCE;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_tx_allowance  = m_allow_reg;
    assign m_window_out    = m_window_reg;
    assign m_threshold_out = m_thresh_reg;
    assign m_inflight_out  = m_inflight_reg;
    assign m_phase         = m_phase_reg;

    // accepted event always enters execution
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted event did not enter execution");

    // divider answers only while the sequencer waits for it
    a_md_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> state_reg == ST_CONG_WAIT)
        else $error("multiply-divide result outside congestion wait");

    // congestion result lands in threshold and enters recovery
    a_cong_update: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONG_WAIT && md_rsp.done |=>
        in_recovery_reg && threshold_reg == $past(md_rsp.quot))
        else $error("congestion result not applied");

    // flush always clears the pending loss
    a_flush_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH_END |=> !loss_pending_reg)
        else $error("loss still pending after flush");

    // result phase is a defined code
    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_phase != 2'd3)
        else $error("undefined phase code");

endmodule
